// ===== hw/rtl/kbcs_pkg.sv =====
// ============================================================================
// kbcs_pkg
// Shared types and constants for the fixed-step two-well battery model.
// ============================================================================
`default_nettype none

package kbcs_pkg;

    // Charge word width (Q16.16) and coefficient fraction bits (Q2.30)
    localparam int CHARGE_WIDTH   = 32;
    localparam int COEF_WIDTH     = 32;
    localparam int FRAC_IN_WIDTH  = 31;
    localparam int COEF_FRAC_BITS = 30;
    localparam int TICK_WIDTH     = 32;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam int          CFG_INDEX_WIDTH  = 3;
    localparam logic [2:0]  CFG_DECAY        = 3'd0;
    localparam logic [2:0]  CFG_AVAIL_MIX    = 3'd1;
    localparam logic [2:0]  CFG_AVAIL_DRAIN  = 3'd2;
    localparam logic [2:0]  CFG_BOUND_MIX    = 3'd3;
    localparam logic [2:0]  CFG_BOUND_DRAIN  = 3'd4;
    localparam logic [2:0]  CFG_AVAIL_FRAC   = 3'd5;
    localparam logic [2:0]  CFG_EMPTY_RATIO  = 3'd6;

    // Reset values of the configuration registers
    localparam logic signed [COEF_WIDTH-1:0] DECAY_RST        = 32'sd1073741366;
    localparam logic signed [COEF_WIDTH-1:0] AVAIL_MIX_RST    = 32'sd286;
    localparam logic signed [COEF_WIDTH-1:0] AVAIL_DRAIN_RST  = 32'sd10737418;
    localparam logic signed [COEF_WIDTH-1:0] BOUND_MIX_RST    = 32'sd172;
    localparam logic signed [COEF_WIDTH-1:0] BOUND_DRAIN_RST  = 32'sd1;
    localparam logic [FRAC_IN_WIDTH-1:0]     AVAIL_FRAC_RST   = 31'd671088640;
    localparam logic [FRAC_IN_WIDTH-1:0]     EMPTY_RATIO_RST  = 31'd32212255;

    // Request kinds
    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    // One classified request
    typedef struct packed {
        item_kind_t                       kind;
        logic signed [CHARGE_WIDTH-1:0]   capacity;   // zero-extended
        logic signed [CHARGE_WIDTH-1:0]   current;
    } item_t;

    // Configuration bundle handed to the back end
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0]  decay_coef;
        logic signed [COEF_WIDTH-1:0]  avail_mix_coef;
        logic signed [COEF_WIDTH-1:0]  avail_drain_coef;
        logic signed [COEF_WIDTH-1:0]  bound_mix_coef;
        logic signed [COEF_WIDTH-1:0]  bound_drain_coef;
        logic [FRAC_IN_WIDTH-1:0]      avail_fraction;
        logic [FRAC_IN_WIDTH-1:0]      empty_ratio;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kbcs_front.sv =====
// ============================================================================
// kbcs_front
// Accepts requests, classifies them as load or tick, and queues them.
// ============================================================================
`default_nettype none

module kbcs_front
    import kbcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [30:0] capacity, [62:31] current, [63] zero
    input  wire logic [0:0]  s_axis_tuser,   // [0] action
    output item_t            head,
    output logic             head_valid,
    input  wire logic        pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             push;
    logic             do_pop;
    item_t            incoming;

    // Classify the incoming request
    always_comb begin
        incoming.kind     = s_axis_tuser[0] ? KIND_TICK : KIND_LOAD;
        incoming.capacity = $signed({1'b0, s_axis_tdata[30:0]});
        incoming.current  = $signed(s_axis_tdata[62:31]);
    end

    assign s_axis_tready = (fill_reg != CW'(DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head_valid    = (fill_reg != '0);
    assign do_pop        = pop && head_valid;
    assign head          = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && do_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kbcs_back.sv =====
// ============================================================================
// kbcs_back
// Sequencer and datapath that carry out load and tick requests on the wells.
// ============================================================================
`default_nettype none

module kbcs_back
    import kbcs_pkg::*;
#(
    parameter int FRAC_BITS = COEF_FRAC_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire item_t        head,
    input  wire logic         head_valid,
    output logic              pop,
    input  wire cfg_t         cfg,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] available_charge, [63:32] bound_charge, [95:64] remaining_charge,
    // [96] is_empty, [128:97] elapsed_ticks, [135:129] zero
    output logic [135:0]      m_axis_tdata
);

    localparam int CW    = CHARGE_WIDTH;
    localparam int PW    = 2 * COEF_WIDTH;
    localparam int TW    = PW - FRAC_BITS;
    localparam int SW    = TW + 2;
    localparam int LANES = 6;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [PW-1:0] HALF   = PW'(1) << (FRAC_BITS - 1);
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_RND  = 8'b0000_0100,
        ST_UPD  = 8'b0000_1000,
        ST_MUL2 = 8'b0001_0000,
        ST_RND2 = 8'b0010_0000,
        ST_LVL  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Well state
    logic signed [CW-1:0]  avail_reg, avail_next;
    logic signed [CW-1:0]  bound_reg, bound_next;
    logic signed [CW-1:0]  total_reg, total_next;
    logic signed [CW-1:0]  level_reg, level_next;
    logic                  flag_reg, flag_next;
    logic [TICK_WIDTH-1:0] count_reg, count_next;

    // Request in flight
    logic                  load_reg, load_next;
    logic                  upd_reg, upd_next;
    logic signed [CW-1:0]  cap_reg;
    logic signed [CW-1:0]  cur_reg;

    // Products and rounded terms
    logic signed [PW-1:0]  prod_reg [LANES];
    logic signed [TW-1:0]  term_reg [LANES];
    logic signed [COEF_WIDTH-1:0] opa [LANES];
    logic signed [COEF_WIDTH-1:0] opb [LANES];

    logic signed [SW-1:0]  sum_avail;
    logic signed [SW-1:0]  sum_bound;
    logic signed [CW-1:0]  rem_now;
    logic                  out_free;
    logic                  take;

    // Clamp to the signed charge range
    function automatic logic signed [CW-1:0] sat_charge(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI) begin
            r = CW'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = CW'(SAT_LO);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign take     = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign pop      = take && head_valid;

    // Multiplier operand selection
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            opa[i] = '0;
            opb[i] = '0;
        end
        if (state_reg == ST_MUL2) begin
            opa[0] = $signed({1'b0, cfg.empty_ratio});
            opb[0] = avail_reg;
        end else if (load_reg) begin
            opa[0] = $signed({1'b0, cfg.avail_fraction});
            opb[0] = cap_reg;
        end else begin
            opa[0] = cfg.decay_coef;       opb[0] = avail_reg;
            opa[1] = cfg.avail_mix_coef;   opb[1] = total_reg;
            opa[2] = cfg.avail_drain_coef; opb[2] = cur_reg;
            opa[3] = cfg.decay_coef;       opb[3] = bound_reg;
            opa[4] = cfg.bound_mix_coef;   opb[4] = total_reg;
            opa[5] = cfg.bound_drain_coef; opb[5] = cur_reg;
        end
    end

    // Product and rounding stages
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_MUL) || (state_reg == ST_MUL2)) begin
            for (int i = 0; i < LANES; i++) begin
                prod_reg[i] <= PW'(opa[i]) * PW'(opb[i]);
            end
        end
        // round half away from zero: (p + half - sign) >>> frac
        if ((state_reg == ST_RND) || (state_reg == ST_RND2)) begin
            for (int i = 0; i < LANES; i++) begin
                term_reg[i] <= TW'((prod_reg[i] + HALF - PW'(prod_reg[i][PW-1]))
                                   >>> FRAC_BITS);
            end
        end
    end

    // Well sums of a tick
    assign sum_avail = SW'(term_reg[0]) + SW'(term_reg[1]) - SW'(term_reg[2]);
    assign sum_bound = SW'(term_reg[3]) + SW'(term_reg[4]) - SW'(term_reg[5]);
    assign rem_now   = sat_charge(SW'(avail_reg) + SW'(bound_reg));

    // Sequencer and state update
    always_comb begin
        state_next = state_reg;
        avail_next = avail_reg;
        bound_next = bound_reg;
        total_next = total_reg;
        level_next = level_reg;
        flag_next  = flag_reg;
        count_next = count_reg;
        load_next  = load_reg;
        upd_next   = upd_reg;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_MUL:  state_next = ST_RND;
            ST_RND:  state_next = ST_UPD;
            ST_UPD: begin
                if (load_reg) begin
                    avail_next = sat_charge(SW'(term_reg[0]));
                    state_next = ST_MUL2;
                end else begin
                    avail_next = sat_charge(sum_avail);
                    bound_next = sat_charge(sum_bound);
                    if (count_reg != TICK_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_MUL2: begin
                bound_next = sat_charge(SW'(cap_reg) - SW'(avail_reg));
                state_next = ST_RND2;
            end
            ST_RND2: state_next = ST_LVL;
            ST_LVL: begin
                level_next = sat_charge(SW'(term_reg[0]));
                flag_next  = 1'b0;
                count_next = '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    flag_next  = flag_reg || (upd_reg && (avail_reg < level_reg));
                    total_next = rem_now;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Dispatch the next request
        if (pop) begin
            load_next = (head.kind == KIND_LOAD);
            if (head.kind == KIND_LOAD) begin
                upd_next   = 1'b0;
                state_next = ST_MUL;
            end else if (flag_next) begin
                upd_next   = 1'b0;
                state_next = ST_DONE;
            end else begin
                upd_next   = 1'b1;
                state_next = ST_MUL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            avail_reg <= '0;
            bound_reg <= '0;
            total_reg <= '0;
            level_reg <= '0;
            flag_reg  <= 1'b0;
            count_reg <= '0;
            load_reg  <= 1'b0;
            upd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            avail_reg <= avail_next;
            bound_reg <= bound_next;
            total_reg <= total_next;
            level_reg <= level_next;
            flag_reg  <= flag_next;
            count_reg <= count_next;
            load_reg  <= load_next;
            upd_reg   <= upd_next;
        end
    end

    // Request operands
    always_ff @(posedge aclk) begin
        if (pop) begin
            cap_reg <= head.capacity;
            cur_reg <= head.current;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_axis_tdata <= {7'd0, count_reg,
                             flag_reg || (upd_reg && (avail_reg < level_reg)),
                             rem_now, bound_reg, avail_reg};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kinetic_battery_charge_step.sv =====
// ============================================================================
// kinetic_battery_charge_step
// Fixed-step two-well battery model: load and tick requests in, one result
// per request out, with a request queue between intake and the update engine.
// ============================================================================
// Sequence: a tick request walks the MUL, RND and UPD states to DONE, a load
//   request also walks MUL2, RND2 and LVL after UPD; a tick on an empty battery goes to DONE.
// Throughput: one tick on an empty battery per cycle while results are taken;
//   a new request waits until the last one reaches DONE, set by the multiply, round
//   and update sequence that each well step walks before the next step can use it.
// Reset: aresetn (synchronous, low) clears wells, threshold, empty latch,
//   tick count and queue, and restores the configuration defaults.
// ============================================================================
`default_nettype none

module kinetic_battery_charge_step
    import kbcs_pkg::*;
#(
    parameter int COEF_FRAC = COEF_FRAC_BITS,
    parameter int Q_DEPTH   = QUEUE_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Request channel
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [63:0]                 s_axis_tdata,  // [30:0] capacity, [62:31] current
    input  wire logic [0:0]                  s_axis_tuser,  // [0] action
    // Result channel
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [31:0] available_charge, [63:32] bound_charge, [95:64] remaining_charge,
    // [96] is_empty, [128:97] elapsed_ticks
    output logic [135:0]                     m_axis_tdata,
    // Configuration writes
    input  wire logic                        cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [COEF_WIDTH-1:0]       cfg_wdata
);

    cfg_t  cfg_reg;
    item_t head;
    logic  head_valid;
    logic  pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decay_coef       <= DECAY_RST;
            cfg_reg.avail_mix_coef   <= AVAIL_MIX_RST;
            cfg_reg.avail_drain_coef <= AVAIL_DRAIN_RST;
            cfg_reg.bound_mix_coef   <= BOUND_MIX_RST;
            cfg_reg.bound_drain_coef <= BOUND_DRAIN_RST;
            cfg_reg.avail_fraction   <= AVAIL_FRAC_RST;
            cfg_reg.empty_ratio      <= EMPTY_RATIO_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_DECAY:       cfg_reg.decay_coef       <= $signed(cfg_wdata);
                CFG_AVAIL_MIX:   cfg_reg.avail_mix_coef   <= $signed(cfg_wdata);
                CFG_AVAIL_DRAIN: cfg_reg.avail_drain_coef <= $signed(cfg_wdata);
                CFG_BOUND_MIX:   cfg_reg.bound_mix_coef   <= $signed(cfg_wdata);
                CFG_BOUND_DRAIN: cfg_reg.bound_drain_coef <= $signed(cfg_wdata);
                CFG_AVAIL_FRAC:  cfg_reg.avail_fraction   <= cfg_wdata[FRAC_IN_WIDTH-1:0];
                CFG_EMPTY_RATIO: cfg_reg.empty_ratio      <= cfg_wdata[FRAC_IN_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Intake and request queue
    kbcs_front #(
        .DEPTH (Q_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop)
    );

    // Well update engine and result register
    kbcs_back #(
        .FRAC_BITS (COEF_FRAC)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .cfg           (cfg_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== tb/sv/kbcs_result_checker.sv =====
// ============================================================================
// kbcs_result_checker
// Watches the request and result channels of the two-well battery model.
// Each accepted request is run through a local copy of the well arithmetic;
// each accepted result is compared field by field with the oldest prediction.
// ============================================================================

module kbcs_result_checker
    import kbcs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,   // [30:0] capacity, [62:31] current
    input  logic [0:0]                 s_axis_tuser,   // [0] action
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [31:0] available_charge, [63:32] bound_charge, [95:64] remaining_charge,
    // [96] is_empty, [128:97] elapsed_ticks
    input  logic [135:0]               m_axis_tdata,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COEF_WIDTH-1:0]      cfg_wdata,
    output int                         pending,
    output int                         mismatches
);

    localparam longint CHARGE_MAX = 64'sd2147483647;
    localparam longint CHARGE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] avail;
        logic [31:0] bound;
        logic [31:0] total;
        logic        empty;
        logic [31:0] ticks;
    } charge_report_t;

    charge_report_t expected_reports[$];

    // Coefficients and fractions as currently written
    longint k_decay, k_avail_mix, k_avail_drain, k_bound_mix, k_bound_drain;
    longint f_avail, f_empty;

    // Battery state
    longint      avail_well, bound_well, empty_level;
    logic        empty_latched;
    logic [31:0] ticks_since_load;

    int bad_count = 0;
    assign mismatches = bad_count;

    function automatic longint clamp_charge(input longint v);
        if (v > CHARGE_MAX) return CHARGE_MAX;
        if (v < CHARGE_MIN) return CHARGE_MIN;
        return v;
    endfunction

    // k*x in Q2.30, rounded half away from zero, magnitude capped at 2^61
    function automatic longint coef_times(input longint k, input longint x);
        logic [127:0] prod;
        logic [63:0]  mk, mx;
        logic         neg;
        longint       m;
        neg  = (k < 0) != (x < 0);
        mk   = (k < 0) ? -k : k;
        mx   = (x < 0) ? -x : x;
        prod = {64'd0, mk} * {64'd0, mx};
        prod = (prod + (128'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
        if (prod > (128'd1 << 61)) prod = 128'd1 << 61;
        m = longint'(prod[63:0]);
        return neg ? -m : m;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (bad_count < 200)
            $display("MISMATCH %s: got %h expected %h", what, got, want);
        bad_count++;
    endtask

    // Apply one request to the local state and queue the result it yields
    task automatic step_wells(input item_kind_t kind, input logic [30:0] cap,
                              input logic signed [31:0] cur);
        longint         c, tot, na, nb;
        charge_report_t r;
        if (kind == KIND_LOAD) begin
            c                = clamp_charge(longint'(cap));
            avail_well       = clamp_charge(coef_times(f_avail, c));
            bound_well       = clamp_charge(c - avail_well);
            empty_level      = clamp_charge(coef_times(f_empty, avail_well));
            empty_latched    = 1'b0;
            ticks_since_load = '0;
        end else if (!empty_latched) begin
            tot = clamp_charge(avail_well + bound_well);
            na  = clamp_charge(coef_times(k_decay, avail_well)
                               + coef_times(k_avail_mix, tot)
                               - coef_times(k_avail_drain, longint'(cur)));
            nb  = clamp_charge(coef_times(k_decay, bound_well)
                               + coef_times(k_bound_mix, tot)
                               - coef_times(k_bound_drain, longint'(cur)));
            avail_well = na;
            bound_well = nb;
            if (ticks_since_load != '1) ticks_since_load++;
            if (avail_well < empty_level) empty_latched = 1'b1;
        end
        r.avail = avail_well[31:0];
        r.bound = bound_well[31:0];
        tot     = clamp_charge(avail_well + bound_well);
        r.total = tot[31:0];
        r.empty = empty_latched;
        r.ticks = ticks_since_load;
        expected_reports.push_back(r);
    endtask

    task automatic compare_result();
        charge_report_t want;
        if (expected_reports.size() == 0) begin
            flag_mismatch("result with nothing expected", m_axis_tdata[31:0], 32'd0);
        end else begin
            want = expected_reports.pop_front();
            if (m_axis_tdata[31:0] !== want.avail)
                flag_mismatch("available_charge", m_axis_tdata[31:0], want.avail);
            if (m_axis_tdata[63:32] !== want.bound)
                flag_mismatch("bound_charge", m_axis_tdata[63:32], want.bound);
            if (m_axis_tdata[95:64] !== want.total)
                flag_mismatch("remaining_charge", m_axis_tdata[95:64], want.total);
            if (m_axis_tdata[96] !== want.empty)
                flag_mismatch("is_empty", {31'd0, m_axis_tdata[96]}, {31'd0, want.empty});
            if (m_axis_tdata[128:97] !== want.ticks)
                flag_mismatch("elapsed_ticks", m_axis_tdata[128:97], want.ticks);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            k_decay          = longint'(DECAY_RST);
            k_avail_mix      = longint'(AVAIL_MIX_RST);
            k_avail_drain    = longint'(AVAIL_DRAIN_RST);
            k_bound_mix      = longint'(BOUND_MIX_RST);
            k_bound_drain    = longint'(BOUND_DRAIN_RST);
            f_avail          = longint'(AVAIL_FRAC_RST);
            f_empty          = longint'(EMPTY_RATIO_RST);
            avail_well       = 0;
            bound_well       = 0;
            empty_level      = 0;
            empty_latched    = 1'b0;
            ticks_since_load = '0;
            expected_reports.delete();
            pending <= 0;
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DECAY:       k_decay       = longint'($signed(cfg_wdata));
                    CFG_AVAIL_MIX:   k_avail_mix   = longint'($signed(cfg_wdata));
                    CFG_AVAIL_DRAIN: k_avail_drain = longint'($signed(cfg_wdata));
                    CFG_BOUND_MIX:   k_bound_mix   = longint'($signed(cfg_wdata));
                    CFG_BOUND_DRAIN: k_bound_drain = longint'($signed(cfg_wdata));
                    CFG_AVAIL_FRAC:  f_avail       = longint'(cfg_wdata[30:0]);
                    CFG_EMPTY_RATIO: f_empty       = longint'(cfg_wdata[30:0]);
                    default: ;
                endcase
            end
            // a result never belongs to a request accepted at the same edge
            if (m_axis_tvalid && m_axis_tready) compare_result();
            if (s_axis_tvalid && s_axis_tready)
                step_wells(item_kind_t'(s_axis_tuser[0]), s_axis_tdata[30:0],
                           s_axis_tdata[62:31]);
            pending <= expected_reports.size();
        end
    end

endmodule

// ===== tb/sv/kinetic_battery_charge_step_tb.sv =====
// ============================================================================
// kinetic_battery_charge_step_tb
// Drives load and tick requests into the two-well battery model: a directed
// pass over field extremes, empty latching and coefficient corners, then
// random load-and-discharge runs under several register settings and three
// backpressure patterns. A separate checker predicts and compares results.
// ============================================================================

module kinetic_battery_charge_step_tb
    import kbcs_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 9;
    localparam int REQS_PER_PHASE = 66;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [63:0]                s_axis_tdata = '0;   // [30:0] capacity, [62:31] current
    logic [0:0]                 s_axis_tuser = '0;   // [0] action
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // [31:0] available_charge, [63:32] bound_charge, [95:64] remaining_charge,
    // [96] is_empty, [128:97] elapsed_ticks
    logic [135:0]               m_axis_tdata;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [COEF_WIDTH-1:0]      cfg_wdata = '0;

    int          pending;
    int          mismatches;
    int          send_idle_pct = 25;
    int          ready_idle_pct = 58;
    int unsigned cycle_count = 0;

    kinetic_battery_charge_step dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    kbcs_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side backpressure
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= ready_idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One request; returns right after the edge that accepted it, valid still high
    task automatic send_req(input item_kind_t kind, input logic [30:0] cap,
                            input logic [31:0] cur);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, cur, cap};
        s_axis_tuser  <= kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Hold off until every request has produced its result, then let the pipe settle
    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_settings(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DECAY;
        cfg_wdata <= c.decay_coef;
        @(posedge aclk);
        cfg_index <= CFG_AVAIL_MIX;
        cfg_wdata <= c.avail_mix_coef;
        @(posedge aclk);
        cfg_index <= CFG_AVAIL_DRAIN;
        cfg_wdata <= c.avail_drain_coef;
        @(posedge aclk);
        cfg_index <= CFG_BOUND_MIX;
        cfg_wdata <= c.bound_mix_coef;
        @(posedge aclk);
        cfg_index <= CFG_BOUND_DRAIN;
        cfg_wdata <= c.bound_drain_coef;
        @(posedge aclk);
        cfg_index <= CFG_AVAIL_FRAC;
        cfg_wdata <= {1'b0, c.avail_fraction};
        @(posedge aclk);
        cfg_index <= CFG_EMPTY_RATIO;
        cfg_wdata <= {1'b0, c.empty_ratio};
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] corner_word();
        case ($urandom_range(2))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [30:0] corner_frac();
        case ($urandom_range(2))
            0:       return 31'h7FFF_FFFF;
            1:       return 31'h4000_0000;
            default: return 31'h0;
        endcase
    endfunction

    // 0: plausible battery, 1: anything, 2: corners
    function automatic cfg_t pick_settings(input int style);
        cfg_t c;
        case (style)
            0: begin
                c.decay_coef       = 32'h4000_0000 - $urandom_range(1 << 20);
                c.avail_mix_coef   = $urandom_range(4096);
                c.avail_drain_coef = $urandom_range(1 << 25);
                c.bound_mix_coef   = $urandom_range(4096);
                c.bound_drain_coef = $urandom_range(64);
                c.avail_fraction   = $urandom_range(1 << 30);
                c.empty_ratio      = $urandom_range(1 << 28);
            end
            1: begin
                c.decay_coef       = $urandom;
                c.avail_mix_coef   = $urandom;
                c.avail_drain_coef = $urandom;
                c.bound_mix_coef   = $urandom;
                c.bound_drain_coef = $urandom;
                c.avail_fraction   = 31'($urandom);
                c.empty_ratio      = 31'($urandom);
            end
            default: begin
                c.decay_coef       = corner_word();
                c.avail_mix_coef   = corner_word();
                c.avail_drain_coef = corner_word();
                c.bound_mix_coef   = corner_word();
                c.bound_drain_coef = corner_word();
                c.avail_fraction   = corner_frac();
                c.empty_ratio      = corner_frac();
            end
        endcase
        return c;
    endfunction

    task automatic run_directed();
        cfg_t c;
        // ticks before any load, then empty latch on the zero state, then hold
        send_req(KIND_TICK, 31'd0, 32'd0);
        send_req(KIND_TICK, 31'd0, 32'h7FFF_FFFF);
        send_req(KIND_TICK, 31'd0, 32'h8000_0000);
        // load of zero capacity with a stray current
        send_req(KIND_LOAD, 31'd0, 32'hFFFF_FFFF);
        send_req(KIND_TICK, 31'h7FFF_FFFF, 32'd0);
        // full capacity, charging ticks
        send_req(KIND_LOAD, 31'h7FFF_FFFF, 32'd0);
        send_req(KIND_TICK, 31'd0, 32'h8000_0000);
        send_req(KIND_TICK, 31'd0, 32'h8000_0000);
        send_req(KIND_TICK, 31'd0, 32'd1);
        // heavy discharge until empty, then held ticks
        send_req(KIND_LOAD, 31'(1000 << 16), 32'd0);
        send_req(KIND_TICK, 31'd0, 32'h7FFF_FFFF);
        send_req(KIND_TICK, 31'd0, 32'h7FFF_FFFF);
        send_req(KIND_TICK, 31'd0, 32'h7FFF_FFFF);
        send_req(KIND_TICK, 31'd0, 32'd0);
        drain_wait();

        // largest decay and mix coefficients, most negative drain coefficients, fraction near two, no empty threshold
        c.decay_coef       = 32'h7FFF_FFFF;
        c.avail_mix_coef   = 32'h7FFF_FFFF;
        c.avail_drain_coef = 32'h8000_0000;
        c.bound_mix_coef   = 32'h7FFF_FFFF;
        c.bound_drain_coef = 32'h8000_0000;
        c.avail_fraction   = 31'h7FFF_FFFF;
        c.empty_ratio      = 31'd0;
        write_settings(c);
        send_req(KIND_LOAD, 31'h7FFF_FFFF, 32'd0);
        send_req(KIND_TICK, 31'd0, 32'h8000_0000);
        send_req(KIND_TICK, 31'd0, 32'h7FFF_FFFF);
        send_req(KIND_TICK, 31'd0, 32'd0);
        drain_wait();

        // most negative decay and mix coefficients, largest drain coefficients, nothing in the available well
        c.decay_coef       = 32'h8000_0000;
        c.avail_mix_coef   = 32'h8000_0000;
        c.avail_drain_coef = 32'h7FFF_FFFF;
        c.bound_mix_coef   = 32'h8000_0000;
        c.bound_drain_coef = 32'h7FFF_FFFF;
        c.avail_fraction   = 31'd0;
        c.empty_ratio      = 31'h7FFF_FFFF;
        write_settings(c);
        send_req(KIND_LOAD, 31'h7FFF_FFFF, 32'd0);
        send_req(KIND_TICK, 31'd0, 32'h8000_0000);
        send_req(KIND_TICK, 31'd0, 32'h7FFF_FFFF);
        send_req(KIND_LOAD, 31'd0, 32'd0);
        send_req(KIND_TICK, 31'd0, 32'h7FFF_FFFF);
        drain_wait();
    endtask

    // Load followed by a discharge run, with some stray requests mixed in
    task automatic run_random_phase(input int phase);
        int         sent;
        int         run_len;
        int         shift;
        logic [30:0] cap;
        longint     cur_mag;
        sent = 0;
        while (sent < REQS_PER_PHASE) begin
            if ($urandom_range(9) == 0) begin
                send_req(item_kind_t'($urandom_range(1)), 31'($urandom), $urandom);
                sent++;
            end else begin
                cap = 31'($urandom >> $urandom_range(24));
                send_req(KIND_LOAD, cap, $urandom);
                run_len = $urandom_range(30, 2);
                shift   = $urandom_range(9);
                sent++;
                for (int i = 0; i < run_len; i++) begin
                    cur_mag = (longint'($urandom_range(cap)) << shift) >> 3;
                    if (cur_mag > 64'sd2147483647) cur_mag = 64'sd2147483647;
                    if ($urandom_range(99) < 15) cur_mag = -cur_mag;
                    send_req(KIND_TICK, 31'($urandom), 32'(cur_mag));
                    sent++;
                end
            end
            // in phase 4 the sender holds off until all results are in, after each burst in mid-phase
            if (phase == 4 && sent >= REQS_PER_PHASE / 2 && sent < REQS_PER_PHASE / 2 + 32)
                drain_wait();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // backpressure pattern: sender-light, then receiver-light, then none
            if (p == 3) begin
                send_idle_pct  <= 58;
                ready_idle_pct <= 25;
            end else if (p == 6) begin
                send_idle_pct  <= 0;
                ready_idle_pct <= 0;
            end
            write_settings(pick_settings((p % 4 == 3) ? 2 : (p % 2)));
            run_random_phase(p);
            drain_wait();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== kinetic_battery_charge_step.f =====
hw/rtl/kbcs_pkg.sv
hw/rtl/kbcs_front.sv
hw/rtl/kbcs_back.sv
hw/rtl/kinetic_battery_charge_step.sv
tb/sv/kbcs_result_checker.sv
tb/sv/kinetic_battery_charge_step_tb.sv
